FILE: src/uartbf_pkg.sv
// Package with action codes, field widths and shared types for the buffered UART ring pair.
package uartbf_pkg;

    // Action codes carried in the slave-side tuser.
    localparam logic [2:0] ACT_HOST_WR  = 3'd0;
    localparam logic [2:0] ACT_HOST_RD  = 3'd1;
    localparam logic [2:0] ACT_RX_CHAR  = 3'd2;
    localparam logic [2:0] ACT_TX_DONE  = 3'd3;
    localparam logic [2:0] ACT_LINE_ERR = 3'd4;
    localparam logic [2:0] ACT_CLR_RX   = 3'd5;
    localparam logic [2:0] ACT_CLR_ERR  = 3'd6;

    // Latched error codes.
    localparam logic [2:0] ERR_NONE = 3'd0;

    // Fixed field widths.
    localparam int BYTE_W   = 8;
    localparam int ACTION_W = 3;
    localparam int KIND_W   = 2;
    localparam int ERR_W    = 3;
    localparam int IN_DATA_W = 16;

    // Command from the controller to one ring.
    typedef struct packed {
        logic push;
        logic pop;
        logic clear;
    } t_ring_cmd;

    // Per-item result flags held between accept and response.
    typedef struct packed {
        logic tx_valid;
        logic rd_valid;
        logic wr_acc;
    } t_resp_flags;

endpackage

FILE: src/uart_buffered_fifo_pair.sv
// Top level of the buffered UART front end: action decoder, flags and two byte rings.
//
//  Channel   | Dir | Signals                          | Contents
//  ----------+-----+----------------------------------+-----------------------------------
//  slave     | in  | i_s_tvalid/o_s_tready            | one action item
//            |     | i_s_tdata[15:0], i_s_tuser[2:0]  | data, error_kind / action
//  master    | out | o_m_tvalid/i_m_tready            | one result item per action
//            |     | o_m_tdata                        | tx_valid .. tx_level
//
// For each item, the accept cycle updates pointers, flags and issues the ring
// read, and the next cycle captures the registered memory read data into the result register.
// A new item is taken while the result waits only if it is taken in the same cycle.
// Reset is synchronous and active low; it empties both rings and clears the flags.
// Ring storage holds no reset value and needs no clearing pass.
// A stalled result holds its value until i_m_tready is seen high.
module uart_buffered_fifo_pair #(
    parameter int RX_DEPTH = 256,
    parameter int TX_DEPTH = 256
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    // [7:0] data, [9:8] error_kind, [15:10] zero
    input  logic [15:0]            i_s_tdata,
    // [2:0] action
    input  logic [2:0]             i_s_tuser,
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    // [0] tx_valid, [8:1] tx_byte, [9] rd_valid, [17:10] rd_byte, [18] write_accepted,
    // [21:19] error_code, [22] sending, then rx_level, then tx_level, then zero fill
    output logic [((23 + $clog2(RX_DEPTH+1) + $clog2(TX_DEPTH+1) + 7) / 8) * 8 - 1:0]
                                   o_m_tdata
);

    localparam int RXL_W   = $clog2(RX_DEPTH+1);
    localparam int TXL_W   = $clog2(TX_DEPTH+1);
    localparam int RES_W   = 23 + RXL_W + TXL_W;
    localparam int OUT_W   = ((RES_W + 7) / 8) * 8;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_RESP = 1'b1;

    logic r_state, n_state;
    logic r_busy, n_busy;
    logic [uartbf_pkg::ERR_W-1:0] r_err, n_err;
    uartbf_pkg::t_resp_flags r_flags, n_flags;
    logic r_out_valid;
    logic [OUT_W-1:0] r_out_data;
    logic [RES_W-1:0] res_word;

    uartbf_pkg::t_ring_cmd rx_cmd, tx_cmd;
    logic [uartbf_pkg::BYTE_W-1:0] rx_rd_data, tx_rd_data;
    logic [RXL_W-1:0] rx_fill;
    logic [TXL_W-1:0] tx_fill;
    logic rx_empty, rx_full, tx_empty, tx_full;

    logic s_accept;
    logic [uartbf_pkg::ACTION_W-1:0] action;
    logic [uartbf_pkg::BYTE_W-1:0] in_byte;
    logic [uartbf_pkg::KIND_W-1:0] err_kind;

    assign action   = i_s_tuser;
    assign in_byte  = i_s_tdata[7:0];
    assign err_kind = i_s_tdata[9:8];

    assign o_s_tready = (r_state == S_IDLE) && (!r_out_valid || i_m_tready);
    assign s_accept   = i_s_tvalid && o_s_tready;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    // Action decode: ring commands and flag updates at the accept edge.
    always_comb begin
        rx_cmd  = '0;
        tx_cmd  = '0;
        n_flags = r_flags;
        n_busy  = r_busy;
        n_err   = r_err;
        if (s_accept) begin
            n_flags = '0;
            unique case (action)
                uartbf_pkg::ACT_HOST_WR: begin
                    if (!tx_full) begin
                        tx_cmd.push    = 1'b1;
                        n_flags.wr_acc = 1'b1;
                        if (!r_busy) begin
                            n_busy           = 1'b1;
                            tx_cmd.pop       = 1'b1;
                            n_flags.tx_valid = 1'b1;
                        end
                    end
                end
                uartbf_pkg::ACT_HOST_RD: begin
                    if (!rx_empty) begin
                        rx_cmd.pop       = 1'b1;
                        n_flags.rd_valid = 1'b1;
                    end
                end
                uartbf_pkg::ACT_RX_CHAR: begin
                    rx_cmd.push = !rx_full;
                end
                uartbf_pkg::ACT_TX_DONE: begin
                    if (!tx_empty) begin
                        tx_cmd.pop       = 1'b1;
                        n_flags.tx_valid = 1'b1;
                    end else begin
                        n_busy = 1'b0;
                    end
                end
                uartbf_pkg::ACT_LINE_ERR: begin
                    n_err = {1'b0, err_kind} + 3'd1;
                end
                uartbf_pkg::ACT_CLR_RX: begin
                    rx_cmd.clear = 1'b1;
                end
                uartbf_pkg::ACT_CLR_ERR: begin
                    n_err = uartbf_pkg::ERR_NONE;
                end
                default: begin
                end
            endcase
        end
    end

    // Sequencer: accept, then capture the response in the next cycle.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (s_accept) begin
                    n_state = S_RESP;
                end
            end
            S_RESP: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_busy      <= 1'b0;
            r_err       <= uartbf_pkg::ERR_NONE;
            r_flags     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= n_busy;
            r_err   <= n_err;
            r_flags <= n_flags;
            if (r_state == S_RESP) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Packed result fields; a byte field reads zero unless its valid flag is set.
    assign res_word = {tx_fill,
                       rx_fill,
                       r_busy,
                       r_err,
                       r_flags.wr_acc,
                       (r_flags.rd_valid ? rx_rd_data : {uartbf_pkg::BYTE_W{1'b0}}),
                       r_flags.rd_valid,
                       (r_flags.tx_valid ? tx_rd_data : {uartbf_pkg::BYTE_W{1'b0}}),
                       r_flags.tx_valid};

    // Result register, loaded once the ring read data is available.
    always_ff @(posedge i_clk) begin
        if (r_state == S_RESP) begin
            r_out_data <= OUT_W'(res_word);
        end
    end

    uartbf_ring #(
        .DEPTH (RX_DEPTH)
    ) u_rx_ring (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (rx_cmd),
        .i_data    (in_byte),
        .o_rd_data (rx_rd_data),
        .o_fill    (rx_fill),
        .o_empty   (rx_empty),
        .o_full    (rx_full)
    );

    uartbf_ring #(
        .DEPTH (TX_DEPTH)
    ) u_tx_ring (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (tx_cmd),
        .i_data    (in_byte),
        .o_rd_data (tx_rd_data),
        .o_fill    (tx_fill),
        .o_empty   (tx_empty),
        .o_full    (tx_full)
    );

endmodule

FILE: src/uartbf_ring.sv
// Ring buffer of bytes in a synchronous memory with head, tail and fill count.
module uartbf_ring #(
    parameter int DEPTH = 256
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  uartbf_pkg::t_ring_cmd               i_cmd,
    input  logic [uartbf_pkg::BYTE_W-1:0]       i_data,
    output logic [uartbf_pkg::BYTE_W-1:0]       o_rd_data,
    output logic [$clog2(DEPTH+1)-1:0]          o_fill,
    output logic                                o_empty,
    output logic                                o_full
);

    localparam int ADDR_W = $clog2(DEPTH);
    localparam int FILL_W = $clog2(DEPTH+1);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);
    localparam logic [FILL_W-1:0] FULL_FILL = FILL_W'(DEPTH);

    logic [uartbf_pkg::BYTE_W-1:0] mem [DEPTH];
    logic [ADDR_W-1:0] r_head, n_head;
    logic [ADDR_W-1:0] r_tail, n_tail;
    logic [FILL_W-1:0] r_fill, n_fill;
    logic [uartbf_pkg::BYTE_W-1:0] r_rd_data;

    assign o_empty   = (r_fill == '0);
    assign o_full    = (r_fill == FULL_FILL);
    assign o_fill    = r_fill;
    assign o_rd_data = r_rd_data;

    // Next pointers and fill; a push and pop together keep the fill unchanged.
    always_comb begin
        n_head = r_head;
        n_tail = r_tail;
        n_fill = r_fill;
        if (i_cmd.clear) begin
            n_head = '0;
            n_tail = '0;
            n_fill = '0;
        end else begin
            if (i_cmd.push) begin
                n_head = (r_head == LAST_ADDR) ? '0 : r_head + 1'b1;
            end
            if (i_cmd.pop) begin
                n_tail = (r_tail == LAST_ADDR) ? '0 : r_tail + 1'b1;
            end
            if (i_cmd.push && !i_cmd.pop) begin
                n_fill = r_fill + 1'b1;
            end else if (i_cmd.pop && !i_cmd.push) begin
                n_fill = r_fill - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_tail <= '0;
            r_fill <= '0;
        end else begin
            r_head <= n_head;
            r_tail <= n_tail;
            r_fill <= n_fill;
        end
    end

    // Byte storage: one write port at the head.
    always_ff @(posedge i_clk) begin
        if (i_cmd.push && !i_cmd.clear) begin
            mem[r_head] <= i_data;
        end
    end

    // Registered read at the tail; an empty ring popped with a push forwards the new byte.
    always_ff @(posedge i_clk) begin
        if (i_cmd.pop && !i_cmd.clear) begin
            if (o_empty) begin
                r_rd_data <= i_data;
            end else begin
                r_rd_data <= mem[r_tail];
            end
        end
    end

endmodule

FILE: src/uartbf_checker.sv
// Port-level checker for the buffered UART ring pair, bound to the top level.
module uartbf_checker #(
    parameter int OUT_W = 48
) (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_s_tvalid,
    input logic             o_s_tready,
    input logic             o_m_tvalid,
    input logic             i_m_tready,
    input logic [OUT_W-1:0] o_m_tdata
);

    // A result waiting for the sink keeps its contents.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> $stable(o_m_tdata))
        else $error("result changed while stalled");

    // A byte field reads zero unless its valid flag is set.
    a_tx_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tdata[0] |-> (o_m_tdata[8:1] == 8'd0))
        else $error("tx byte nonzero without tx valid");

    a_rd_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tdata[9] |-> (o_m_tdata[17:10] == 8'd0))
        else $error("read byte nonzero without read valid");

    // A stored host byte always leaves the transmitter busy.
    a_acc_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[18] |-> o_m_tdata[22])
        else $error("write accepted but not sending");

    // An accepted item blocks the input for the cycle after it.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("second item taken while a response is pending");

endmodule

bind uart_buffered_fifo_pair uartbf_checker #(
    .OUT_W (OUT_W)
) u_uartbf_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);

FILE: tb/uart_fifo_pair_checker.sv
// Checker for the buffered UART ring pair: predicts each result item and compares it.
module uart_fifo_pair_checker #(
    parameter int RX_DEPTH = 256,
    parameter int TX_DEPTH = 256,
    parameter int RXL_W    = $clog2(RX_DEPTH + 1),
    parameter int TXL_W    = $clog2(TX_DEPTH + 1),
    parameter int M_W      = ((23 + RXL_W + TXL_W + 7) / 8) * 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_tvalid,
    input  logic                                i_s_tready,
    // [7:0] data, [9:8] error_kind, [15:10] zero
    input  logic [uartbf_pkg::IN_DATA_W-1:0]    i_s_tdata,
    // [2:0] action
    input  logic [uartbf_pkg::ACTION_W-1:0]     i_s_tuser,
    input  logic                                i_m_tvalid,
    input  logic                                i_m_tready,
    // [0] tx_valid, [8:1] tx_byte, [9] rd_valid, [17:10] rd_byte, [18] write_accepted,
    // [21:19] error_code, [22] sending, then rx_level, then tx_level
    input  logic [M_W-1:0]                      i_m_tdata,
    output int                                  o_pending,
    output int                                  o_fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    // One result item split into its fields.
    typedef struct {
        bit                          tx_valid;
        bit [uartbf_pkg::BYTE_W-1:0] tx_byte;
        bit                          rd_valid;
        bit [uartbf_pkg::BYTE_W-1:0] rd_byte;
        bit                          wr_acc;
        bit [uartbf_pkg::ERR_W-1:0]  err_code;
        bit                          sending;
        bit [RXL_W-1:0]              rx_level;
        bit [TXL_W-1:0]              tx_level;
    } t_line_status;

    // Shadow copy of both rings, the busy flag and the error latch.
    bit [uartbf_pkg::BYTE_W-1:0] rx_mem [RX_DEPTH];
    bit [uartbf_pkg::BYTE_W-1:0] tx_mem [TX_DEPTH];
    int unsigned     rx_wr, rx_rd, rx_cnt;
    int unsigned     tx_wr, tx_rd, tx_cnt;
    bit              tx_busy;
    bit [uartbf_pkg::ERR_W-1:0] err_latched;

    t_line_status    status_q [$];
    int unsigned     result_idx;

    initial o_fail_count = 0;

    // Take the oldest byte of the transmit ring.
    function automatic bit [uartbf_pkg::BYTE_W-1:0] tx_take();
        bit [uartbf_pkg::BYTE_W-1:0] b;
        b      = tx_mem[tx_rd];
        tx_rd  = (tx_rd + 1) % TX_DEPTH;
        tx_cnt = tx_cnt - 1;
        return b;
    endfunction

    // Apply one action to the shadow state and return the status it produces.
    function automatic t_line_status advance_rings(logic [uartbf_pkg::ACTION_W-1:0] act,
                                                   bit [uartbf_pkg::BYTE_W-1:0] din,
                                                   bit [uartbf_pkg::KIND_W-1:0] kind);
        t_line_status r;
        r = '{default: 0};
        case (act)
            uartbf_pkg::ACT_HOST_WR: begin
                if (tx_cnt < TX_DEPTH) begin
                    tx_mem[tx_wr] = din;
                    tx_wr         = (tx_wr + 1) % TX_DEPTH;
                    tx_cnt        = tx_cnt + 1;
                    r.wr_acc      = 1'b1;
                    // An idle transmitter is started and gets a byte at once.
                    if (!tx_busy) begin
                        tx_busy    = 1'b1;
                        r.tx_byte  = tx_take();
                        r.tx_valid = 1'b1;
                    end
                end
            end
            uartbf_pkg::ACT_HOST_RD: begin
                if (rx_cnt > 0) begin
                    r.rd_byte  = rx_mem[rx_rd];
                    r.rd_valid = 1'b1;
                    rx_rd      = (rx_rd + 1) % RX_DEPTH;
                    rx_cnt     = rx_cnt - 1;
                end
            end
            uartbf_pkg::ACT_RX_CHAR: begin
                // A full receive ring drops the byte silently.
                if (rx_cnt < RX_DEPTH) begin
                    rx_mem[rx_wr] = din;
                    rx_wr         = (rx_wr + 1) % RX_DEPTH;
                    rx_cnt        = rx_cnt + 1;
                end
            end
            uartbf_pkg::ACT_TX_DONE: begin
                if (tx_cnt > 0) begin
                    r.tx_byte  = tx_take();
                    r.tx_valid = 1'b1;
                end else begin
                    tx_busy = 1'b0;
                end
            end
            uartbf_pkg::ACT_LINE_ERR: err_latched = {1'b0, kind} + 3'd1;
            uartbf_pkg::ACT_CLR_RX: begin
                // Stale entries are never read again, so only the pointers matter.
                rx_wr  = 0;
                rx_rd  = 0;
                rx_cnt = 0;
            end
            uartbf_pkg::ACT_CLR_ERR: err_latched = uartbf_pkg::ERR_NONE;
            default: ;
        endcase
        r.err_code = err_latched;
        r.sending  = tx_busy;
        r.rx_level = RXL_W'(rx_cnt);
        r.tx_level = TXL_W'(tx_cnt);
        return r;
    endfunction

    // Print one mismatch line and count it.
    task automatic report_mismatch(string what, int unsigned got, int unsigned want);
        $display("[%0t] result item %0d: %s is %0h, expected %0h",
                 $realtime, result_idx, what, got, want);
        o_fail_count++;
    endtask

    // Watch both channels; results are checked before new items are predicted.
    always @(posedge i_clk) begin : watch
        t_line_status want, got;
        if (!i_rst_n) begin
            rx_wr       = 0;
            rx_rd       = 0;
            rx_cnt      = 0;
            tx_wr       = 0;
            tx_rd       = 0;
            tx_cnt      = 0;
            tx_busy     = 1'b0;
            err_latched = uartbf_pkg::ERR_NONE;
            status_q.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                got.tx_valid = i_m_tdata[0];
                got.tx_byte  = i_m_tdata[8:1];
                got.rd_valid = i_m_tdata[9];
                got.rd_byte  = i_m_tdata[17:10];
                got.wr_acc   = i_m_tdata[18];
                got.err_code = i_m_tdata[21:19];
                got.sending  = i_m_tdata[22];
                got.rx_level = i_m_tdata[23 +: RXL_W];
                got.tx_level = i_m_tdata[23 + RXL_W +: TXL_W];
                if (status_q.size() == 0) begin
                    report_mismatch("item with nothing expected, tdata", 0, 0);
                end else begin
                    want = status_q.pop_front();
                    if (got.tx_valid != want.tx_valid)
                        report_mismatch("tx_valid", got.tx_valid, want.tx_valid);
                    if (got.tx_byte != want.tx_byte)
                        report_mismatch("tx_byte", got.tx_byte, want.tx_byte);
                    if (got.rd_valid != want.rd_valid)
                        report_mismatch("rd_valid", got.rd_valid, want.rd_valid);
                    if (got.rd_byte != want.rd_byte)
                        report_mismatch("rd_byte", got.rd_byte, want.rd_byte);
                    if (got.wr_acc != want.wr_acc)
                        report_mismatch("write_accepted", got.wr_acc, want.wr_acc);
                    if (got.err_code != want.err_code)
                        report_mismatch("error_code", got.err_code, want.err_code);
                    if (got.sending != want.sending)
                        report_mismatch("sending", got.sending, want.sending);
                    if (got.rx_level != want.rx_level)
                        report_mismatch("rx_level", got.rx_level, want.rx_level);
                    if (got.tx_level != want.tx_level)
                        report_mismatch("tx_level", got.tx_level, want.tx_level);
                end
                result_idx++;
            end
            if (i_s_tvalid && i_s_tready)
                status_q.push_back(advance_rings(i_s_tuser, i_s_tdata[7:0], i_s_tdata[9:8]));
        end
        o_pending <= status_q.size();
    end

endmodule

FILE: tb/tb_top.sv
// Testbench top for the buffered UART ring pair: clock, reset, item traffic and verdict.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RX_DEPTH = 256;
    localparam int TX_DEPTH = 256;
    localparam int RXL_W    = $clog2(RX_DEPTH + 1);
    localparam int TXL_W    = $clog2(TX_DEPTH + 1);
    localparam int M_W      = ((23 + RXL_W + TXL_W + 7) / 8) * 8;

    // Action code outside the defined set, and the line error kinds.
    localparam logic [2:0] ACT_UNUSED    = 3'd7;
    localparam logic [1:0] KIND_PARITY   = 2'd0;
    localparam logic [1:0] KIND_FRAMING  = 2'd1;
    localparam logic [1:0] KIND_OVERFLOW = 2'd2;
    localparam logic [1:0] KIND_BREAK    = 2'd3;

    localparam int FLOOD_LEN      = 300;
    localparam int RAND_PER_PHASE = 340;
    localparam int HOLD_CYCLES    = 300;

    typedef enum {MIX_ALL, RX_HEAVY, TX_HEAVY, DRAIN_HEAVY} t_traffic_mix;

    logic                i_clk      = 1'b0;
    logic                i_rst_n    = 1'b0;
    logic                i_s_tvalid = 1'b0;
    logic                o_s_tready;
    logic [15:0]         i_s_tdata  = '0;
    logic [2:0]          i_s_tuser  = '0;
    logic                o_m_tvalid;
    logic                i_m_tready = 1'b0;
    logic [M_W-1:0]      o_m_tdata;

    int phase_sel = 0;
    int tx_idle_pct;
    int rx_idle_pct;
    int pending;
    int fail_count;

    uart_buffered_fifo_pair #(
        .RX_DEPTH(RX_DEPTH),
        .TX_DEPTH(TX_DEPTH)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    uart_fifo_pair_checker #(
        .RX_DEPTH(RX_DEPTH),
        .TX_DEPTH(TX_DEPTH)
    ) checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (i_s_tvalid),
        .i_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_s_tuser    (i_s_tuser),
        .i_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .i_m_tdata    (o_m_tdata),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Idle rates per phase: sender light and receiver heavy, then swapped, then none.
    always_comb begin
        case (phase_sel)
            0: begin
                tx_idle_pct = 29;
                rx_idle_pct = 68;
            end
            1: begin
                tx_idle_pct = 68;
                rx_idle_pct = 29;
            end
            default: begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
        endcase
    end

    // Receiver: random ready, with one long hold-off at the start of the second phase.
    initial begin
        int hold_left;
        bit hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        forever begin
            @(negedge i_clk);
            if (phase_sel == 1 && !hold_done) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // Offer one item after a random gap and hold it until it is taken.
    task automatic send_item(logic [2:0] act, bit [7:0] din, bit [1:0] kind);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= act;
        i_s_tdata  <= {6'b0, kind, din};
        do @(posedge i_clk); while (!o_s_tready);
        @(negedge i_clk);
    endtask

    // Stop offering and wait until every expected result item has come back.
    task automatic settle();
        i_s_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    initial begin
        t_traffic_mix mode;
        int           burst;
        int           sent;
        int           pct;
        logic [2:0]   act;
        logic [2:0]   noise;

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty rings, transmit start and drain, receive path, errors.
        send_item(uartbf_pkg::ACT_HOST_RD, 8'h00, KIND_PARITY);
        send_item(uartbf_pkg::ACT_TX_DONE, 8'hFF, KIND_BREAK);
        send_item(uartbf_pkg::ACT_HOST_WR, 8'h00, KIND_PARITY);
        send_item(uartbf_pkg::ACT_HOST_WR, 8'hFF, KIND_BREAK);
        send_item(uartbf_pkg::ACT_HOST_WR, 8'hA5, KIND_FRAMING);
        send_item(uartbf_pkg::ACT_TX_DONE, 8'h00, KIND_PARITY);
        send_item(uartbf_pkg::ACT_TX_DONE, 8'h00, KIND_PARITY);
        send_item(uartbf_pkg::ACT_TX_DONE, 8'h00, KIND_PARITY);
        send_item(uartbf_pkg::ACT_TX_DONE, 8'h00, KIND_PARITY);
        send_item(uartbf_pkg::ACT_RX_CHAR, 8'h00, KIND_PARITY);
        send_item(uartbf_pkg::ACT_RX_CHAR, 8'hFF, KIND_BREAK);
        send_item(uartbf_pkg::ACT_RX_CHAR, 8'h5A, KIND_OVERFLOW);
        send_item(uartbf_pkg::ACT_HOST_RD, 8'h00, KIND_PARITY);
        send_item(uartbf_pkg::ACT_CLR_RX, 8'hFF, KIND_BREAK);
        send_item(uartbf_pkg::ACT_HOST_RD, 8'h00, KIND_PARITY);
        send_item(uartbf_pkg::ACT_LINE_ERR, 8'h00, KIND_PARITY);
        send_item(uartbf_pkg::ACT_LINE_ERR, 8'h00, KIND_FRAMING);
        send_item(uartbf_pkg::ACT_LINE_ERR, 8'hFF, KIND_OVERFLOW);
        send_item(uartbf_pkg::ACT_LINE_ERR, 8'hFF, KIND_BREAK);
        send_item(uartbf_pkg::ACT_CLR_ERR, 8'h00, KIND_BREAK);
        send_item(ACT_UNUSED, 8'hC3, KIND_FRAMING);
        send_item(uartbf_pkg::ACT_RX_CHAR, 8'h3C, KIND_PARITY);
        send_item(uartbf_pkg::ACT_HOST_RD, 8'h00, KIND_PARITY);
        settle();

        // Random traffic in bursts; the first two phases open by flooding one ring
        // past full so that dropped bytes and refused writes are exercised.
        for (int p = 0; p < 3; p++) begin
            phase_sel <= p;
            sent = 0;
            while (sent < RAND_PER_PHASE) begin
                if (sent == 0 && p < 2) begin
                    mode  = (p == 0) ? RX_HEAVY : TX_HEAVY;
                    burst = FLOOD_LEN;
                end else begin
                    mode  = t_traffic_mix'($urandom_range(3));
                    burst = $urandom_range(40, 10);
                end
                repeat (burst) begin
                    pct = $urandom_range(99);
                    case ($urandom_range(5))
                        0:       noise = uartbf_pkg::ACT_HOST_WR;
                        1:       noise = uartbf_pkg::ACT_HOST_RD;
                        2:       noise = uartbf_pkg::ACT_RX_CHAR;
                        3:       noise = uartbf_pkg::ACT_TX_DONE;
                        4:       noise = uartbf_pkg::ACT_LINE_ERR;
                        default: noise = uartbf_pkg::ACT_CLR_ERR;
                    endcase
                    case (mode)
                        RX_HEAVY:    act = (pct < 90) ? uartbf_pkg::ACT_RX_CHAR : noise;
                        TX_HEAVY:    act = (pct < 90) ? uartbf_pkg::ACT_HOST_WR : noise;
                        DRAIN_HEAVY: act = (pct < 45) ? uartbf_pkg::ACT_HOST_RD :
                                           (pct < 90) ? uartbf_pkg::ACT_TX_DONE : noise;
                        default:     act = (pct < 4) ? uartbf_pkg::ACT_CLR_RX : noise;
                    endcase
                    send_item(act, 8'($urandom_range(255)), 2'($urandom_range(3)));
                    sent++;
                end
            end
            settle();
        end

        // Let any stray result item surface before the verdict.
        repeat (8) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // Run limit.
    initial begin
        #2000000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
